FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the classifier core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define FCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FCC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FCC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/fcc_pkg.sv
`default_nettype none

package fcc_pkg;

    // configuration field widths
    localparam int FRAME_W    = 11;
    localparam int MARGIN_W   = 9;
    localparam int DECIDE_W   = 10;
    localparam int THRESH_W   = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    localparam int PIX_W       = 8;
    localparam int CAM_W       = 2;
    localparam int COLOUR_W    = 3;
    localparam int NUM_CLASSES = 4;

    // default parameter values
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_COUNT_BITS = 16;

    // register reset values
    localparam logic [FRAME_W-1:0]  RST_FRAME_WIDTH  = 11'd64;
    localparam logic [FRAME_W-1:0]  RST_FRAME_HEIGHT = 11'd64;
    localparam logic [MARGIN_W-1:0] RST_EDGE_MARGIN  = 9'd0;
    localparam logic [DECIDE_W-1:0] RST_DECIDE_COUNT = 10'd20;
    localparam logic [THRESH_W-1:0] RST_HIGH_CAM0    = 8'd90;
    localparam logic [THRESH_W-1:0] RST_LOW_CAM0     = 8'd35;
    localparam logic [THRESH_W-1:0] RST_HIGH_OTHER   = 8'd180;
    localparam logic [THRESH_W-1:0] RST_LOW_OTHER    = 8'd70;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_EDGE_MARGIN  = 3'd2,
        REG_DECIDE_COUNT = 3'd3,
        REG_HIGH_CAM0    = 3'd4,
        REG_LOW_CAM0     = 3'd5,
        REG_HIGH_OTHER   = 3'd6,
        REG_LOW_OTHER    = 3'd7
    } cfg_index_t;

    typedef enum logic [COLOUR_W-1:0] {
        COL_NONE  = 3'd0,
        COL_WHITE = 3'd1,
        COL_RED   = 3'd2,
        COL_BLUE  = 3'd3,
        COL_GREEN = 3'd4
    } colour_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_width;
        logic [FRAME_W-1:0]  frame_height;
        logic [MARGIN_W-1:0] edge_margin;
        logic [DECIDE_W-1:0] decide_count;
        logic [THRESH_W-1:0] high_cam0;
        logic [THRESH_W-1:0] low_cam0;
        logic [THRESH_W-1:0] high_other;
        logic [THRESH_W-1:0] low_other;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [CAM_W-1:0] camera_index;
        logic             frame_start;
    } pixel_t;

    typedef struct packed {
        logic emit;
        logic decided;
    } trk_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/frame_colour_classifier_core.sv
`default_nettype none

// Frame colour classifier. Takes raster-order RGB pixels, one per clock, and
// gives one colour transaction per frame: the first colour whose class count
// alone passes decide_count, or none at the last pixel of the frame. A pixel
// with frame_start high opens a new frame and latches its camera index. The
// block sustains one pixel per cycle; a pixel goes through an input register
// and then the count/position update, which writes the result register, so
// a colour is registered by the deciding pixel's update step. While a colour
// waits on m_ready the update step holds and the input stalls once its
// register is full. The loop through the class counters and the decision
// compare sets that rate. Registers must be written through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module frame_colour_classifier_core import fcc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // pixel channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIX_W-1:0]      s_red,
    input  wire logic [PIX_W-1:0]      s_green,
    input  wire logic [PIX_W-1:0]      s_blue,
    input  wire logic [CAM_W-1:0]      s_camera_index,
    input  wire logic                  s_frame_start,
    // colour channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [COLOUR_W-1:0]        m_colour
);

    `include "assert_macros.svh"

    cfg_t        cfg_reg, cfg_next;
    pixel_t      pix_reg, pix_next;
    logic        in_valid_reg, in_valid_next;
    logic        m_valid_reg, m_valid_next;
    colour_t     m_colour_reg, m_colour_next;
    logic        step_en;
    trk_status_t status;
    colour_t     colour;

    // register file, to be written only while idle; the block does not enforce it
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[FRAME_W-1:0];
                REG_EDGE_MARGIN:  cfg_next.edge_margin  = cfg_data[MARGIN_W-1:0];
                REG_DECIDE_COUNT: cfg_next.decide_count = cfg_data[DECIDE_W-1:0];
                REG_HIGH_CAM0:    cfg_next.high_cam0    = cfg_data[THRESH_W-1:0];
                REG_LOW_CAM0:     cfg_next.low_cam0     = cfg_data[THRESH_W-1:0];
                REG_HIGH_OTHER:   cfg_next.high_other   = cfg_data[THRESH_W-1:0];
                REG_LOW_OTHER:    cfg_next.low_other    = cfg_data[THRESH_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // the update step runs when a pixel is held and the result slot is free
    // or being drained this cycle
    assign step_en = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    always_comb begin
        pix_next      = pix_reg;
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            pix_next      = '{red: s_red, green: s_green, blue: s_blue,
                              camera_index: s_camera_index,
                              frame_start: s_frame_start};
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end

        // result register parts the colour channel from the update step
        m_valid_next  = m_valid_reg;
        m_colour_next = m_colour_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (step_en && status.emit) begin
            m_valid_next  = 1'b1;
            m_colour_next = colour;
        end
    end

    fcc_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .pix     (pix_reg),
        .cfg     (cfg_reg),
        .status  (status),
        .colour  (colour)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '{frame_width:  RST_FRAME_WIDTH,
                              frame_height: RST_FRAME_HEIGHT,
                              edge_margin:  RST_EDGE_MARGIN,
                              decide_count: RST_DECIDE_COUNT,
                              high_cam0:    RST_HIGH_CAM0,
                              low_cam0:     RST_LOW_CAM0,
                              high_other:   RST_HIGH_OTHER,
                              low_other:    RST_LOW_OTHER};
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        pix_reg      <= pix_next;
        m_colour_reg <= m_colour_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_colour = m_colour_reg;

    // a new colour transaction only follows an update step
    `FCC_ASSERT_IMP(a_result_from_step, aclk, aresetn, $rose(m_valid), $past(step_en))
    // a frame is closed once its colour is produced
    `FCC_ASSERT_NXT(a_decided_after_emit, aclk, aresetn, step_en && status.emit,
                    status.decided)
    // at most one colour per frame
    `FCC_ASSERT_IMP(a_single_result, aclk, aresetn,
                    step_en && status.decided && !pix_reg.frame_start, !status.emit)

endmodule

`default_nettype wire

FILE: hw/rtl/fcc_pixel_class.sv
`default_nettype none

// one-hot class of a pixel: bit 0 white, 1 red, 2 blue, 3 green
module fcc_pixel_class import fcc_pkg::*; (
    input  wire logic [PIX_W-1:0]       red,
    input  wire logic [PIX_W-1:0]       green,
    input  wire logic [PIX_W-1:0]       blue,
    input  wire logic [THRESH_W-1:0]    high_thresh,
    input  wire logic [THRESH_W-1:0]    low_thresh,
    output logic      [NUM_CLASSES-1:0] hit
);

    logic r_hi, g_hi, b_hi, r_lo, g_lo, b_lo;

    always_comb begin
        r_hi = red > high_thresh;
        g_hi = green > high_thresh;
        b_hi = blue > high_thresh;
        r_lo = red < low_thresh;
        g_lo = green < low_thresh;
        b_lo = blue < low_thresh;
        hit  = '0;
        if (r_hi && g_hi && b_hi) begin
            hit[0] = 1'b1;
        end else if (r_hi && b_lo && g_lo) begin
            hit[1] = 1'b1;
        end else if (r_lo && b_hi && g_lo) begin
            hit[2] = 1'b1;
        end else if (r_lo && b_lo && g_hi) begin
            hit[3] = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fcc_tracker.sv
`default_nettype none

// frame position, class counts and decision, one pixel per step
module fcc_tracker import fcc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   step_en,
    input  wire pixel_t pix,
    input  wire cfg_t   cfg,
    output trk_status_t status,
    output colour_t     colour
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CALC_W  = $clog2(DIM_MAX + 2 ** FRAME_W) + 1;
    localparam int CMP_W   = (COUNT_BITS > DECIDE_W) ? COUNT_BITS : DECIDE_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] cnt_reg  [NUM_CLASSES];
    logic [COUNT_BITS-1:0] cnt_next [NUM_CLASSES];
    logic [COUNT_BITS-1:0] cnt0     [NUM_CLASSES];
    logic [COUNT_BITS-1:0] cnt1     [NUM_CLASSES];
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  decided_reg, decided_next;
    logic [CAM_W-1:0]      cam_reg, cam_next;

    logic [CALC_W-1:0]      fw, fh, w, h, mg, col0, row0, col1, row1a, row1, col2;
    logic                   dec0, in_win, last, found;
    logic [CAM_W-1:0]       cam;
    logic [THRESH_W-1:0]    hi, lo;
    logic [NUM_CLASSES-1:0] hit, nz, gt, only;
    logic [1:0]             cidx;

    fcc_pixel_class u_class (
        .red         (pix.red),
        .green       (pix.green),
        .blue        (pix.blue),
        .high_thresh (hi),
        .low_thresh  (lo),
        .hit         (hit)
    );

    always_comb begin
        // clamp frame size to the supported range
        fw = CALC_W'(cfg.frame_width);
        fh = CALC_W'(cfg.frame_height);
        mg = CALC_W'(cfg.edge_margin);
        if (fw == '0) begin
            w = CALC_W'(1);
        end else if (fw > CALC_W'(MAX_WIDTH)) begin
            w = CALC_W'(MAX_WIDTH);
        end else begin
            w = fw;
        end
        if (fh == '0) begin
            h = CALC_W'(1);
        end else if (fh > CALC_W'(MAX_HEIGHT)) begin
            h = CALC_W'(MAX_HEIGHT);
        end else begin
            h = fh;
        end

        // frame start clears the state before the pixel is handled
        col0 = pix.frame_start ? '0 : CALC_W'(col_reg);
        row0 = pix.frame_start ? '0 : CALC_W'(row_reg);
        dec0 = pix.frame_start ? 1'b0 : decided_reg;
        cam  = pix.frame_start ? pix.camera_index : cam_reg;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            cnt0[i] = pix.frame_start ? '0 : cnt_reg[i];
        end

        // position after a size change
        if (col0 >= w) begin
            col1  = '0;
            row1a = (row0 < h) ? row0 + CALC_W'(1) : row0;
        end else begin
            col1  = col0;
            row1a = row0;
        end
        row1 = (row1a > h - CALC_W'(1)) ? h - CALC_W'(1) : row1a;

        hi = (cam == '0) ? cfg.high_cam0 : cfg.high_other;
        lo = (cam == '0) ? cfg.low_cam0 : cfg.low_other;

        in_win = (col1 >= mg) && (col1 + mg < w) && (row1 >= mg) && (row1 + mg < h);

        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (in_win && hit[i] && cnt0[i] != COUNT_MAX) begin
                cnt1[i] = cnt0[i] + COUNT_BITS'(1);
            end else begin
                cnt1[i] = cnt0[i];
            end
            nz[i] = cnt1[i] != '0;
            gt[i] = CMP_W'(cnt1[i]) > CMP_W'(cfg.decide_count);
        end
        for (int i = 0; i < NUM_CLASSES; i++) begin
            only[i] = gt[i] && ((nz & ~(NUM_CLASSES'(1) << i)) == '0);
        end

        // lowest class wins
        found = 1'b0;
        cidx  = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (in_win && only[i]) begin
                found = 1'b1;
                cidx  = 2'(i);
            end
        end
        colour = found ? colour_t'(3'(cidx) + 3'd1) : COL_NONE;

        last = (col1 + CALC_W'(1) >= w) && (row1 + CALC_W'(1) >= h);
        col2 = col1 + CALC_W'(1);

        status.emit    = !dec0 && (found || last);
        status.decided = decided_reg;

        cnt_next     = cnt0;
        col_next     = col0[COL_W-1:0];
        row_next     = row0[ROW_W-1:0];
        decided_next = dec0;
        cam_next     = cam;
        if (!dec0) begin
            cnt_next = cnt1;
            if (found || last) begin
                decided_next = 1'b1;
                col_next     = col1[COL_W-1:0];
                row_next     = row1[ROW_W-1:0];
            end else if (col2 >= w) begin
                col_next = '0;
                row_next = ROW_W'(row1 + CALC_W'(1));
            end else begin
                col_next = col2[COL_W-1:0];
                row_next = row1[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cnt_reg[i] <= '0;
            end
            col_reg     <= '0;
            row_reg     <= '0;
            decided_reg <= 1'b0;
            cam_reg     <= '0;
        end else if (step_en) begin
            cnt_reg     <= cnt_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            decided_reg <= decided_next;
            cam_reg     <= cam_next;
        end
    end

endmodule

`default_nettype wire
